// ===== src/twep_pkg.sv =====
// Package for the triangle weakest-edge pruner: field widths, codes, payload and control types.
package twep_pkg;

    localparam int MAX_NODES_DEF   = 64;
    localparam int MAX_EDGES_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 32;

    localparam int NODE_FIELD_W   = 6;
    localparam int WEIGHT_FIELD_W = 32;
    localparam int EDGE_FIELD_W   = 10;
    localparam int STATUS_W       = 2;
    localparam int GAP_W          = 32;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNADDED = 2'd2;

    localparam logic [GAP_W-1:0] PRUNE_GAP_RESET = 32'd1;

    typedef struct packed {
        logic                      command;
        logic [NODE_FIELD_W-1:0]   node_a;
        logic [NODE_FIELD_W-1:0]   node_b;
        logic [WEIGHT_FIELD_W-1:0] weight;
        logic [EDGE_FIELD_W-1:0]   query_edge;
    } in_item_t;

    typedef struct packed {
        logic                    kept;
        logic [EDGE_FIELD_W-1:0] assigned_edge;
        logic [STATUS_W-1:0]     status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ADJ_BA,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_CMP,
        ST_SCAN_MARK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic commit;
        logic adj_wr_ab;
        logic adj_wr_ba;
        logic rd_removed;
        logic c_clear;
        logic c_inc;
        logic adj_rd;
        logic wt_rd;
        logic cmp_latch;
        logic mark;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic full;
        logic self_loop;
        logic skip_c;
        logic last_c;
        logic triangle;
    } dp_status_t;

endpackage

// ===== src/twep_ctrl.sv =====
// Controller state machine: sequences the clear pass, decode, adjacency update and triangle scan.
module twep_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  twep_pkg::dp_status_t  status,
    output twep_pkg::ctrl_cmd_t   cmd
);

    twep_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= twep_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            twep_pkg::ST_CLEAR: begin
                if (status.clear_last) state_next = twep_pkg::ST_IDLE;
            end
            twep_pkg::ST_IDLE: begin
                if (s_valid) state_next = twep_pkg::ST_DECODE;
            end
            twep_pkg::ST_DECODE: begin
                if (status.is_read || status.full || status.self_loop) begin
                    state_next = twep_pkg::ST_DONE;
                end else begin
                    state_next = twep_pkg::ST_ADJ_BA;
                end
            end
            twep_pkg::ST_ADJ_BA: begin
                state_next = twep_pkg::ST_SCAN_RD;
            end
            twep_pkg::ST_SCAN_RD: begin
                if (!status.skip_c) begin
                    state_next = twep_pkg::ST_SCAN_CHK;
                end else if (status.last_c) begin
                    state_next = twep_pkg::ST_DONE;
                end
            end
            twep_pkg::ST_SCAN_CHK: begin
                if (status.triangle) begin
                    state_next = twep_pkg::ST_SCAN_CMP;
                end else if (status.last_c) begin
                    state_next = twep_pkg::ST_DONE;
                end else begin
                    state_next = twep_pkg::ST_SCAN_RD;
                end
            end
            twep_pkg::ST_SCAN_CMP: begin
                state_next = twep_pkg::ST_SCAN_MARK;
            end
            twep_pkg::ST_SCAN_MARK: begin
                state_next = status.last_c ? twep_pkg::ST_DONE : twep_pkg::ST_SCAN_RD;
            end
            twep_pkg::ST_DONE: begin
                if (out_free) state_next = twep_pkg::ST_IDLE;
            end
            default: begin
                state_next = twep_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            twep_pkg::ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            twep_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            twep_pkg::ST_DECODE: begin
                if (status.is_read) begin
                    cmd.rd_removed = 1'b1;
                end else if (!status.full) begin
                    cmd.commit = 1'b1;
                    if (!status.self_loop) begin
                        cmd.adj_wr_ab = 1'b1;
                        cmd.c_clear   = 1'b1;
                    end
                end
            end
            twep_pkg::ST_ADJ_BA: begin
                cmd.adj_wr_ba = 1'b1;
            end
            twep_pkg::ST_SCAN_RD: begin
                if (!status.skip_c) begin
                    cmd.adj_rd = 1'b1;
                end else if (!status.last_c) begin
                    cmd.c_inc = 1'b1;
                end
            end
            twep_pkg::ST_SCAN_CHK: begin
                if (status.triangle) begin
                    cmd.wt_rd = 1'b1;
                end else if (!status.last_c) begin
                    cmd.c_inc = 1'b1;
                end
            end
            twep_pkg::ST_SCAN_CMP: begin
                cmd.cmp_latch = 1'b1;
            end
            twep_pkg::ST_SCAN_MARK: begin
                cmd.mark  = 1'b1;
                cmd.c_inc = !status.last_c;
            end
            twep_pkg::ST_DONE: begin
                cmd.load_result = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // hold the result until the transaction completes
    always_comb begin
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

// ===== src/twep_dpath.sv =====
// Datapath: adjacency, weight and removed-flag memories, scan counter, triangle compare and result register.
module twep_dpath #(
    parameter int MAX_NODES   = twep_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = twep_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = twep_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  twep_pkg::in_item_t            in_data,
    input  logic                          cfg_wr_en,
    input  logic [twep_pkg::GAP_W-1:0]    cfg_wr_data,
    input  twep_pkg::ctrl_cmd_t           cmd,
    output twep_pkg::dp_status_t          status,
    output twep_pkg::out_item_t           out_data
);

    localparam int ADJ_DEPTH = MAX_NODES * MAX_NODES;
    localparam int NW  = $clog2(MAX_NODES);
    localparam int AW  = $clog2(ADJ_DEPTH);
    localparam int IDW = $clog2(MAX_EDGES);
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int WB  = WEIGHT_BITS;
    localparam int GW  = twep_pkg::GAP_W;
    localparam int DW  = (WB > GW) ? WB : GW;
    localparam int EF  = twep_pkg::EDGE_FIELD_W;
    localparam int QW  = (CW > EF) ? CW : EF;
    localparam int NF  = twep_pkg::NODE_FIELD_W;

    logic [IDW:0]  adj_mem [ADJ_DEPTH];
    logic [WB-1:0] wt_mem  [MAX_EDGES];
    logic          rem_mem [MAX_EDGES];

    logic [GW-1:0] prune_gap_reg;
    logic [CW-1:0] edge_count_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [NF-1:0] a_reg, b_reg;
    logic [WB-1:0] w_reg;
    logic [EF-1:0] q_reg;
    logic          is_read_reg, full_reg, qbad_reg, self_reg;
    logic [AW-1:0] base_a_reg, base_b_reg;
    logic [IDW-1:0] id_reg;
    logic [NW-1:0] c_reg;

    logic [IDW:0]  adj_a_reg, adj_b_reg;
    logic [WB-1:0] w2_reg, w3_reg;
    logic [WB-1:0] lo_reg, mid_reg;
    logic [IDW-1:0] victim_reg;
    logic          rem_rd_reg;
    twep_pkg::out_item_t result_reg, result_next;

    logic          adj_we;
    logic [AW-1:0] adj_waddr;
    logic [IDW:0]  adj_wdata;
    logic          rem_we;
    logic [IDW-1:0] rem_waddr;
    logic          rem_wdata;

    logic [WB-1:0] lo_c, mid_c;
    logic [IDW-1:0] victim_c;
    logic [WB-1:0] diff;
    logic          gap_ok;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prune_gap_reg  <= twep_pkg::PRUNE_GAP_RESET;
            edge_count_reg <= '0;
            clr_addr_reg   <= '0;
        end else begin
            if (cfg_wr_en) prune_gap_reg <= cfg_wr_data;
            if (cmd.commit) edge_count_reg <= edge_count_reg + CW'(1);
            if (cmd.clear_wr) clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // latch the transaction and its decode flags
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg       <= in_data.node_a;
            b_reg       <= in_data.node_b;
            w_reg       <= WB'(in_data.weight);
            q_reg       <= in_data.query_edge;
            is_read_reg <= (in_data.command == twep_pkg::CMD_READ);
            full_reg    <= (32'(edge_count_reg) >= MAX_EDGES);
            qbad_reg    <= (QW'(in_data.query_edge) >= QW'(edge_count_reg))
                           || (32'(in_data.query_edge) >= MAX_EDGES);
            self_reg    <= (in_data.node_a == in_data.node_b)
                           || (32'(in_data.node_a) >= MAX_NODES)
                           || (32'(in_data.node_b) >= MAX_NODES);
            base_a_reg  <= AW'(32'(in_data.node_a) * MAX_NODES);
            base_b_reg  <= AW'(32'(in_data.node_b) * MAX_NODES);
            id_reg      <= IDW'(edge_count_reg);
        end
        if (cmd.c_clear) begin
            c_reg <= '0;
        end else if (cmd.c_inc) begin
            c_reg <= c_reg + NW'(1);
        end
    end

    // adjacency write port: clear pass, then both directions of the new edge
    always_comb begin
        adj_we    = cmd.clear_wr || cmd.adj_wr_ab || cmd.adj_wr_ba;
        adj_waddr = clr_addr_reg;
        adj_wdata = '0;
        if (cmd.adj_wr_ab) begin
            adj_waddr = base_a_reg + AW'(b_reg);
            adj_wdata = {1'b1, id_reg};
        end else if (cmd.adj_wr_ba) begin
            adj_waddr = base_b_reg + AW'(a_reg);
            adj_wdata = {1'b1, id_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
        if (cmd.adj_rd) begin
            adj_a_reg <= adj_mem[base_a_reg + AW'(c_reg)];
            adj_b_reg <= adj_mem[base_b_reg + AW'(c_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) wt_mem[id_reg] <= w_reg;
        if (cmd.wt_rd) begin
            w2_reg <= wt_mem[adj_b_reg[IDW-1:0]];
            w3_reg <= wt_mem[adj_a_reg[IDW-1:0]];
        end
    end

    // smallest and median of the three weights; ties favor the new edge, then the node_b side
    always_comb begin
        logic [WB-1:0] mn12, mx12, mn_x3;
        mn12  = (w_reg < w2_reg) ? w_reg : w2_reg;
        mx12  = (w_reg > w2_reg) ? w_reg : w2_reg;
        mn_x3 = (mx12 < w3_reg) ? mx12 : w3_reg;
        lo_c  = (mn12 < w3_reg) ? mn12 : w3_reg;
        mid_c = (mn12 > mn_x3) ? mn12 : mn_x3;
        if (w_reg == lo_c) begin
            victim_c = id_reg;
        end else if (w2_reg == lo_c) begin
            victim_c = adj_b_reg[IDW-1:0];
        end else begin
            victim_c = adj_a_reg[IDW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cmp_latch) begin
            lo_reg     <= lo_c;
            mid_reg    <= mid_c;
            victim_reg <= victim_c;
        end
    end

    assign diff   = mid_reg - lo_reg;
    assign gap_ok = DW'(diff) >= DW'(prune_gap_reg);

    always_comb begin
        rem_we    = cmd.commit || (cmd.mark && gap_ok);
        rem_waddr = cmd.commit ? id_reg : victim_reg;
        rem_wdata = !cmd.commit;
    end

    always_ff @(posedge aclk) begin
        if (rem_we) rem_mem[rem_waddr] <= rem_wdata;
        if (cmd.rd_removed) rem_rd_reg <= rem_mem[IDW'(q_reg)];
    end

    always_comb begin
        result_next = '0;
        if (is_read_reg) begin
            if (qbad_reg) begin
                result_next.status = twep_pkg::STATUS_UNADDED;
            end else begin
                result_next.kept   = !rem_rd_reg;
                result_next.status = twep_pkg::STATUS_OK;
            end
        end else if (full_reg) begin
            result_next.status = twep_pkg::STATUS_FULL;
        end else begin
            result_next.assigned_edge = EF'(id_reg);
            result_next.status        = twep_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) result_reg <= result_next;
    end

    assign out_data = result_reg;

    always_comb begin
        status.clear_last = (32'(clr_addr_reg) == ADJ_DEPTH - 1);
        status.is_read    = is_read_reg;
        status.full       = full_reg;
        status.self_loop  = self_reg;
        status.skip_c     = (32'(c_reg) == 32'(a_reg)) || (32'(c_reg) == 32'(b_reg));
        status.last_c     = (32'(c_reg) == MAX_NODES - 1);
        status.triangle   = adj_a_reg[IDW] && adj_b_reg[IDW];
    end

endmodule

// ===== src/triangle_weakest_edge_pruner.sv =====
// Top level of the triangle weakest-edge pruner: controller, datapath and port wiring.
//
//  channel  | ports                        | moves
//  ---------+------------------------------+-------------------------------------
//  input    | s_valid s_ready s_data       | add-edge or read-kept command
//  result   | m_valid m_ready m_data       | kept flag, assigned edge id, status
//  config   | cfg_wr_en cfg_wr_data        | prune_gap register write
//
// A read, a dropped add or a self loop add goes from DECODE to DONE, where the result is
// loaded once the output register is free. A linked add writes both adjacency directions,
// then scans every candidate third node: a candidate reads the adjacency port pair, and one
// that closes a triangle also reads and compares the weights. s_ready rises again in the
// cycle after the result is loaded. After reset a clearing pass writes every adjacency
// entry with s_ready low. One command is processed at a time; a finished result waits in
// the output register while the next transaction is accepted and worked on.
module triangle_weakest_edge_pruner #(
    parameter int MAX_NODES   = twep_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = twep_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = twep_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  twep_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output twep_pkg::out_item_t         m_data,
    input  logic                        cfg_wr_en,
    input  logic [twep_pkg::GAP_W-1:0]  cfg_wr_data
);

    twep_pkg::ctrl_cmd_t  cmd;
    twep_pkg::dp_status_t status;

    twep_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    twep_dpath #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_data     (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_data    (m_data)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the triangle weakest-edge pruner: directed plan, random phases.
module tb_top;
    import twep_pkg::*;

    localparam int NODE_SLOTS  = MAX_NODES_DEF;
    localparam int EDGE_SLOTS  = MAX_EDGES_DEF;
    localparam int QUIET_LIMIT = 20000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 215;
    localparam int TAIL_CYCLES = 20;

    typedef enum logic {ROW_CMD, ROW_GAP} plan_kind_t;

    typedef struct {
        plan_kind_t  kind;
        in_item_t    item;
        bit          typed;
        out_item_t   res;
        logic [31:0] gap;
    } plan_row_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_item_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_item_t   m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    triangle_weakest_edge_pruner dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Shadow copy of the pruning state
    bit          adj_ok  [NODE_SLOTS][NODE_SLOTS];
    logic [9:0]  adj_id  [NODE_SLOTS][NODE_SLOTS];
    logic [31:0] edge_w  [EDGE_SLOTS];
    bit          edge_cut[EDGE_SLOTS];
    int unsigned edges_used = 0;
    logic [31:0] gap_now    = PRUNE_GAP_RESET;

    out_item_t   awaited[$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    bit          tx_fast = 1'b0;
    bit          rx_fast = 1'b0;
    int          cluster_base = 0;
    logic [31:0] weight_base  = '0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    // Mark the weakest edge of a triangle when the median clears the minimum by the gap.
    function automatic void judge_triangle(logic [9:0] fresh, logic [9:0] at_b,
                                           logic [9:0] at_a);
        logic [31:0] w1, w2, w3, lo, hi, mid;
        logic [33:0] sum;
        w1 = edge_w[fresh];
        w2 = edge_w[at_b];
        w3 = edge_w[at_a];
        lo = (w1 < w2) ? w1 : w2;
        lo = (lo < w3) ? lo : w3;
        hi = (w1 > w2) ? w1 : w2;
        hi = (hi > w3) ? hi : w3;
        sum = 34'(w1) + 34'(w2) + 34'(w3);
        mid = 32'(sum - 34'(lo) - 34'(hi));
        if (mid - lo < gap_now)
            return;
        if (w1 == lo)
            edge_cut[fresh] = 1'b1;
        else if (w2 == lo)
            edge_cut[at_b] = 1'b1;
        else
            edge_cut[at_a] = 1'b1;
    endfunction

    function automatic out_item_t apply_command(in_item_t x);
        out_item_t  r;
        logic [9:0] id;
        int         a, b;
        r = '0;
        if (x.command == CMD_READ) begin
            if (x.query_edge >= edges_used)
                r.status = STATUS_UNADDED;
            else
                r.kept = !edge_cut[x.query_edge];
            return r;
        end
        if (edges_used >= EDGE_SLOTS) begin
            r.status = STATUS_FULL;
            return r;
        end
        id = EDGE_FIELD_W'(edges_used);
        edges_used++;
        edge_w[id]      = x.weight;
        edge_cut[id]    = 1'b0;
        r.assigned_edge = id;
        a = x.node_a;
        b = x.node_b;
        // a self loop is stored but never linked
        if (a == b)
            return r;
        adj_ok[a][b] = 1'b1;
        adj_id[a][b] = id;
        adj_ok[b][a] = 1'b1;
        adj_id[b][a] = id;
        for (int c = 0; c < NODE_SLOTS; c++) begin
            if (c == a || c == b)
                continue;
            if (adj_ok[a][c] && adj_ok[b][c])
                judge_triangle(id, adj_id[b][c], adj_id[a][c]);
        end
        return r;
    endfunction

    function automatic plan_row_t plan_cmd(logic cmd, int a, int b, logic [31:0] w, int q,
                                           bit typed, logic kept, int edge_id,
                                           logic [STATUS_W-1:0] status);
        plan_row_t r;
        r.kind             = ROW_CMD;
        r.item.command     = cmd;
        r.item.node_a      = NODE_FIELD_W'(a);
        r.item.node_b      = NODE_FIELD_W'(b);
        r.item.weight      = w;
        r.item.query_edge  = EDGE_FIELD_W'(q);
        r.typed            = typed;
        r.res.kept         = kept;
        r.res.assigned_edge = EDGE_FIELD_W'(edge_id);
        r.res.status       = status;
        r.gap              = '0;
        return r;
    endfunction

    function automatic plan_row_t plan_gap(logic [31:0] v);
        plan_row_t r;
        r       = plan_cmd(CMD_ADD, 0, 0, '0, 0, 1'b0, 1'b0, 0, STATUS_OK);
        r.kind  = ROW_GAP;
        r.gap   = v;
        return r;
    endfunction

    function automatic logic [NODE_FIELD_W-1:0] pick_node();
        if ($urandom_range(0, 99) < 70)
            return NODE_FIELD_W'(cluster_base + $urandom_range(0, 6));
        return NODE_FIELD_W'($urandom_range(0, NODE_SLOTS - 1));
    endfunction

    function automatic in_item_t random_command();
        in_item_t    x;
        int unsigned r, k;
        logic [31:0] gap_unit;
        x.command = ($urandom_range(0, 99) < 15) ? CMD_READ : CMD_ADD;
        x.node_a  = pick_node();
        x.node_b  = ($urandom_range(0, 19) == 0) ? x.node_a : pick_node();
        r = $urandom_range(0, 99);
        if (r < 30) begin
            x.weight = $urandom;
        end else if (r < 45) begin
            case ($urandom_range(0, 3))
                0: x.weight = 32'h0000_0000;
                1: x.weight = 32'hFFFF_FFFF;
                2: x.weight = 32'h0000_0001;
                default: x.weight = 32'hFFFF_FFFE;
            endcase
        end else begin
            // cluster weights around multiples of the gap so triangles land near the threshold
            gap_unit = (gap_now == 0) ? 32'd1 : gap_now;
            k = $urandom_range(0, 3);
            x.weight = weight_base + 32'(k) * gap_unit + 32'($urandom_range(0, 2)) - 32'd1;
        end
        if ($urandom_range(0, 99) < 70)
            x.query_edge = EDGE_FIELD_W'($urandom_range(0,
                               (edges_used < EDGE_SLOTS - 1) ? edges_used : EDGE_SLOTS - 1));
        else
            x.query_edge = EDGE_FIELD_W'($urandom);
        return x;
    endfunction

    task automatic send_command(input in_item_t x, input bit typed, input out_item_t typed_res);
        int unsigned pause;
        out_item_t   predicted;
        pause = tx_fast ? 0 : $urandom_range(0, 17);
        if (pause != 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_command(x);
        awaited.push_back(typed ? typed_res : predicted);
    endtask

    // Drop valid, drain all results, then write the gap register.
    task automatic write_prune_gap(input logic [31:0] v);
        s_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gap_now = v;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected result kept=%0d edge=%0d status=%0d",
                                      got.kept, got.assigned_edge, got.status));
            return;
        end
        want = awaited.pop_front();
        if (got.kept !== want.kept)
            report_mismatch($sformatf("kept got %0d want %0d", got.kept, want.kept));
        if (got.assigned_edge !== want.assigned_edge)
            report_mismatch($sformatf("assigned_edge got %0d want %0d",
                                      got.assigned_edge, want.assigned_edge));
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask

    // Result side: random stall before each transaction
    initial begin
        int unsigned stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = rx_fast ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        plan_row_t   plan[$];
        logic [31:0] phase_gap;
        out_item_t   no_res;
        no_res = '0;

        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 0, 1, 0, 0, STATUS_UNADDED));
        plan.push_back(plan_cmd(CMD_READ, 63, 63, 32'hFFFF_FFFF, 1023, 1, 0, 0, STATUS_UNADDED));
        plan.push_back(plan_cmd(CMD_ADD, 0, 1, 32'd100, 0, 1, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_ADD, 1, 2, 32'd200, 0, 1, 0, 1, STATUS_OK));
        plan.push_back(plan_cmd(CMD_ADD, 0, 2, 32'd300, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 2, 0, 0, 0, STATUS_OK));
        // weakest edge sits at node_b
        plan.push_back(plan_cmd(CMD_ADD, 3, 4, 32'd500, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_ADD, 4, 5, 32'd50, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_ADD, 3, 5, 32'd1000, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 4, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_ADD, 9, 9, 32'd1234, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 6, 0, 0, 0, STATUS_OK));
        // duplicate of edge 0-1 replaces its adjacency entries
        plan.push_back(plan_cmd(CMD_ADD, 1, 0, 32'd150, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 7, 0, 0, 0, STATUS_OK));
        // zero gap with an all-equal triangle: the new edge loses the tie
        plan.push_back(plan_gap(32'd0));
        plan.push_back(plan_cmd(CMD_ADD, 6, 7, 32'd7, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_ADD, 7, 8, 32'd7, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_ADD, 6, 8, 32'd7, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 10, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 9, 0, 0, 0, STATUS_OK));
        // largest gap, reached only by a full-scale spread
        plan.push_back(plan_gap(32'hFFFF_FFFF));
        plan.push_back(plan_cmd(CMD_ADD, 63, 0, 32'h0, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_ADD, 62, 63, 32'hFFFF_FFFF, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_ADD, 0, 62, 32'hFFFF_FFFF, 0, 0, 0, 0, STATUS_OK));
        plan.push_back(plan_cmd(CMD_READ, 0, 0, '0, 11, 0, 0, 0, STATUS_OK));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_GAP)
                write_prune_gap(plan[n].gap);
            else
                send_command(plan[n].item, plan[n].typed, plan[n].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: phase_gap = 32'd1;
                1: phase_gap = 32'd0;
                2: phase_gap = 32'h0001_0000;
                3: phase_gap = 32'hFFFF_FFFF;
                4: phase_gap = 32'($urandom_range(2, 32'h0004_0000));
                default: phase_gap = $urandom;
            endcase
            write_prune_gap(phase_gap);
            tx_fast      = ($urandom_range(0, 2) == 0);
            rx_fast      = ($urandom_range(0, 2) == 0);
            cluster_base = $urandom_range(0, NODE_SLOTS - 7);
            weight_base  = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_command(random_command(), 1'b0, no_res);
        end

        s_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
